/* sv/tbrl_pkg.sv */
// shared widths, codes, types and helpers of the token bucket rate limiter
package tbrl_pkg;

    // width of the token counter
    localparam int COUNT_WIDTH = 24;

    // fixed field and register widths
    localparam int FIELD_W = 24;
    localparam int CMD_W   = 3;
    localparam int RATE_W  = 16;
    localparam int IDX_W   = 8;

    // compare width covers both the counter and the byte count field
    localparam int CMP_W = (COUNT_WIDTH > FIELD_W) ? COUNT_WIDTH : FIELD_W;
    // refill sum width: counter or whole bytes per tick, plus one carry-out bit
    localparam int SUM_W = ((COUNT_WIDTH > (RATE_W - 3)) ? COUNT_WIDTH : (RATE_W - 3)) + 1;

    localparam longint unsigned COUNT_MAX_L = (64'd1 << COUNT_WIDTH) - 64'd1;
    localparam logic [CMP_W-1:0] COUNT_MAX_W = CMP_W'(COUNT_MAX_L);

    localparam longint unsigned CAP_RESET  = 64'd65536;
    localparam longint unsigned RATE_RESET = 64'd500;

    // capacity in use after reset, held to what the counter can store
    localparam logic [COUNT_WIDTH-1:0] CAP_RESET_USE =
        COUNT_WIDTH'((CAP_RESET > COUNT_MAX_L) ? COUNT_MAX_L : CAP_RESET);
    localparam logic [RATE_W-1:0] RATE_RESET_V = RATE_W'(RATE_RESET);

    // commands
    localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CHECK   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CONSUME = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PAUSE   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RESUME  = 3'd4;

    // register indexes
    localparam logic [IDX_W-1:0] REG_CAPACITY = 8'd0;
    localparam logic [IDX_W-1:0] REG_RATE     = 8'd1;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [FIELD_W-1:0] byte_count;
    } item_t;

    // item held in the input register, with its valid flag
    typedef struct packed {
        logic  valid;
        item_t item;
    } staged_item_t;

    typedef struct packed {
        logic               allowed;
        logic [FIELD_W-1:0] tokens_left;
        logic               is_full;
        logic               refill_done;
        logic               refused;
    } result_t;

    // capacity in use: saturate at the largest counter value
    function automatic logic [COUNT_WIDTH-1:0] cap_clamp(input logic [FIELD_W-1:0] cap);
        logic [CMP_W-1:0] cap_w;
        cap_w = CMP_W'(cap);
        if (cap_w > COUNT_MAX_W)
        begin
            return COUNT_WIDTH'(COUNT_MAX_W);
        end
        return COUNT_WIDTH'(cap_w);
    endfunction

endpackage

/* sv/tbrl_if.sv */
// channel interfaces: item input, result output and register write

interface tbrl_in_if;
    import tbrl_pkg::*;
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [FIELD_W-1:0] byte_count;

    modport source (output valid, output command, output byte_count, input ready);
    modport sink (input valid, input command, input byte_count, output ready);
endinterface

interface tbrl_out_if;
    import tbrl_pkg::*;
    logic               valid;
    logic               ready;
    logic               allowed;
    logic [FIELD_W-1:0] tokens_left;
    logic               is_full;
    logic               refill_done;
    logic               refused;

    modport source (output valid, output allowed, output tokens_left, output is_full,
                    output refill_done, output refused, input ready);
    modport sink (input valid, input allowed, input tokens_left, input is_full,
                  input refill_done, input refused, output ready);
endinterface

interface tbrl_cfg_if;
    import tbrl_pkg::*;
    logic               valid;
    logic               ready;
    logic [IDX_W-1:0]   index;
    logic [FIELD_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* sv/tbrl_in_stage.sv */
// input register: captures one item per transfer, releases it when the core advances
module tbrl_in_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    tbrl_in_if.sink               item_in,
    input  logic                  advance,
    output tbrl_pkg::staged_item_t staged
);
    import tbrl_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  take;

    // free when empty or when the held item moves on this cycle
    assign item_in.ready = !valid_reg || advance;
    assign take          = item_in.valid && item_in.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.command    <= item_in.command;
            item_reg.byte_count <= item_in.byte_count;
        end
    end

    assign staged.valid = valid_reg;
    assign staged.item  = item_reg;

endmodule

/* sv/tbrl_bucket_core.sv */
// bucket state, single-pass update and result register
module tbrl_bucket_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tbrl_pkg::staged_item_t staged,
    output logic                  advance,
    tbrl_cfg_if.sink              cfg,
    tbrl_out_if.source            result_out
);
    import tbrl_pkg::*;

    logic [COUNT_WIDTH-1:0] cap_reg;
    logic [RATE_W-1:0]      rate_reg;
    logic [COUNT_WIDTH-1:0] token_reg;
    logic [COUNT_WIDTH-1:0] token_next;
    logic [2:0]             carry_reg;
    logic [2:0]             carry_next;
    logic                   armed_reg;
    logic                   armed_next;
    logic                   res_valid_reg;
    logic                   res_valid_next;
    result_t                res_reg;
    result_t                res_next;

    logic                   fire;
    logic                   cfg_wr;
    logic [COUNT_WIDTH-1:0] cap_wr;
    logic [CMP_W-1:0]       tok_w;
    logic [CMP_W-1:0]       want_w;
    logic                   enough;
    logic                   full_now;
    logic [3:0]             carry_sum;
    logic [SUM_W-1:0]       refill_sum;
    logic [COUNT_WIDTH-1:0] refill_tok;

    assign advance = !res_valid_reg || result_out.ready;
    assign fire    = staged.valid && advance;

    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid && cfg.ready;
    assign cap_wr    = cap_clamp(cfg.data);

    // single pass datapath
    assign tok_w      = CMP_W'(token_reg);
    assign want_w     = CMP_W'(staged.item.byte_count);
    assign enough     = tok_w >= want_w;
    assign full_now   = token_reg == cap_reg;
    assign carry_sum  = {1'b0, carry_reg} + {1'b0, rate_reg[2:0]};
    assign refill_sum = SUM_W'(token_reg) + SUM_W'(rate_reg[RATE_W-1:3])
                      + SUM_W'(carry_sum[3]);
    assign refill_tok = (refill_sum > SUM_W'(cap_reg)) ? cap_reg
                                                       : COUNT_WIDTH'(refill_sum);

    always_comb
    begin
        token_next           = token_reg;
        carry_next           = carry_reg;
        armed_next           = armed_reg;
        res_next.allowed     = 1'b0;
        res_next.refill_done = 1'b0;
        res_next.refused     = 1'b0;
        case (staged.item.command)
            CMD_TICK:
            begin
                if (armed_reg)
                begin
                    token_next           = refill_tok;
                    carry_next           = carry_sum[2:0];
                    armed_next           = refill_tok != cap_reg;
                    res_next.refill_done = 1'b1;
                end
            end
            CMD_CHECK:
            begin
                armed_next       = armed_reg || !full_now;
                res_next.allowed = enough;
            end
            CMD_CONSUME:
            begin
                armed_next       = armed_reg || !full_now;
                res_next.allowed = enough;
                res_next.refused = !enough;
                if (enough)
                begin
                    token_next = COUNT_WIDTH'(tok_w - want_w);
                end
            end
            CMD_PAUSE:
            begin
                armed_next = 1'b0;
            end
            CMD_RESUME:
            begin
                armed_next = 1'b1;
            end
            default:
            begin
                token_next = token_reg;
            end
        endcase
        res_next.tokens_left = FIELD_W'(CMP_W'(token_next));
        res_next.is_full     = token_next == cap_reg;
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (fire)
        begin
            res_valid_next = 1'b1;
        end
        else if (result_out.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET_USE;
            rate_reg      <= RATE_RESET_V;
            token_reg     <= CAP_RESET_USE;
            carry_reg     <= 3'd0;
            armed_reg     <= 1'b1;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (cfg_wr && cfg.index == REG_RATE)
            begin
                rate_reg <= cfg.data[RATE_W-1:0];
            end
            if (cfg_wr && cfg.index == REG_CAPACITY)
            begin
                cap_reg   <= cap_wr;
                token_reg <= cap_wr;
            end
            else if (fire)
            begin
                token_reg <= token_next;
                carry_reg <= carry_next;
                armed_reg <= armed_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    assign result_out.valid       = res_valid_reg;
    assign result_out.allowed     = res_reg.allowed;
    assign result_out.tokens_left = res_reg.tokens_left;
    assign result_out.is_full     = res_reg.is_full;
    assign result_out.refill_done = res_reg.refill_done;
    assign result_out.refused     = res_reg.refused;

    // the count never rises above the capacity in use
    assert property (@(posedge clk) disable iff (!rst_n) token_reg <= cap_reg)
        else $error("token count above capacity");

    // a refused consume never reports the bytes as allowed
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.refused |-> !res_reg.allowed)
        else $error("refused result also allowed");

    // a refill result carries no admission outcome
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.refill_done |-> !res_reg.allowed && !res_reg.refused)
        else $error("refill result with admission flags");

    // a refill that fills the bucket disarms refill
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && staged.item.command == CMD_TICK && armed_reg && refill_tok == cap_reg
        |=> !armed_reg)
        else $error("refill stayed armed on a full bucket");

    // an allowed consume takes exactly the asked bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && !cfg_wr && staged.item.command == CMD_CONSUME && enough
        |=> token_reg == $past(token_next))
        else $error("consume did not subtract the asked bytes");

endmodule

/* sv/token_bucket_rate_limiter.sv */
// top level of the byte token bucket rate limiter
//
// byte token bucket with tick-driven refill. each item (tick, check, consume,
// pause or resume) gives exactly one result. the block takes one item per
// cycle, back to back, while the result is taken: an item is captured in the
// input register, the bucket core works out the whole update (refill with
// 3-bit carry and cap, or the admission compare and subtract) in one pass and
// writes the result register. the count, carry and armed flag are updated in
// that same pass, so the next item sees them at once. a stalled result holds
// the core, and the input register holds one more item before item_in.ready
// drops. the register port is always ready; write it only while no item is
// in flight. writing the capacity register refills the bucket to the new
// capacity. after reset the bucket is full and refill armed; there is no
// clearing pass
module token_bucket_rate_limiter (
    input  logic       clk,
    input  logic       rst_n,
    tbrl_in_if.sink    item_in,
    tbrl_cfg_if.sink   cfg,
    tbrl_out_if.source result_out
);
    import tbrl_pkg::*;

    // item waiting in the input register
    staged_item_t staged;
    // core can take the staged item this cycle
    logic         advance;

    tbrl_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .item_in (item_in),
        .advance (advance),
        .staged  (staged)
    );

    // refill and admission in a single pass, result registered
    tbrl_bucket_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .staged     (staged),
        .advance    (advance),
        .cfg        (cfg),
        .result_out (result_out)
    );

endmodule
